### src/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// lsbse_pkg
// Types and constants shared by the LSB embed / extract block.
// ----------------------------------------------------------------------------
package lsbse_pkg;

    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned MIN_PAYLOAD  = 32;
    localparam int unsigned LEN_BYTES    = 4;   // bytes of the 32-bit length word

    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_MODE         = 2'd0;
    localparam logic [1:0] REG_BITS_PER_CH  = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_LEN  = 2'd2;
    localparam logic [1:0] REG_CARRIER_BYTES = 2'd3;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_ZERO_LEN  = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_TOO_SHORT = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_DONE    = 4'b0100,
        PH_ERROR   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] carrier_byte;
        logic [7:0] payload_byte;
        logic       final_carrier;
    } t_in_item;

    typedef struct packed {
        logic [7:0] carrier_out;
        logic       payload_taken;
        logic [7:0] extracted_byte;
        logic       extracted_valid;
        logic       extracted_last;
        logic [2:0] status;
    } t_out_item;

    typedef struct packed {
        logic        mode;
        logic [2:0]  bits_per_channel;
        logic [31:0] payload_length;
        logic [31:0] carrier_bytes;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  chunk_index;
        logic [7:0]  byte_latch;
        logic [31:0] byte_count;
        logic [31:0] stored_length;
        t_phase      phase;
        logic [2:0]  error_code;
    } t_stream;

    // effective chunk width: 0 acts as 1, above 4 acts as 4
    function automatic logic [2:0] eff_width(input logic [2:0] bpc);
        logic [2:0] k;
        if (bpc == 3'd0) begin
            k = 3'd1;
        end else if (bpc inside {[3'd1:3'd4]}) begin
            k = bpc;
        end else begin
            k = 3'd4;
        end
        return k;
    endfunction

    // carrier bytes per payload byte, ceil(8/k)
    function automatic logic [3:0] chunk_count(input logic [2:0] k);
        logic [3:0] n;
        case (k)
            3'd1:    n = 4'd8;
            3'd2:    n = 4'd4;
            3'd3:    n = 4'd3;
            default: n = 4'd2;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] low_mask(input logic [2:0] k);
        logic [7:0] m;
        case (k)
            3'd1:    m = 8'h01;
            3'd2:    m = 8'h03;
            3'd3:    m = 8'h07;
            default: m = 8'h0F;
        endcase
        return m;
    endfunction

endpackage

### src/lsbse_step.sv
// ----------------------------------------------------------------------------
// lsbse_step
// Per-item next-state and result logic for one carrier byte.
// ----------------------------------------------------------------------------
module lsbse_step
    import lsbse_pkg::*;
(
    input  t_cfg      i_cfg,
    input  t_stream   i_cur,
    input  t_in_item  i_item,
    output t_stream   o_nxt,
    output t_out_item o_res
);

    logic [2:0]  k;
    logic [3:0]  chunks;
    logic [7:0]  mask;
    logic [4:0]  sh;
    logic        first;
    logic        last_chunk;
    logic        active;
    logic [31:0] len_src;
    logic [7:0]  hdr_byte;
    logic [7:0]  chunk_val;
    logic [31:0] bc_inc;
    logic [1:0]  hdr_slot;
    t_stream     s;
    t_out_item   r;

    assign k          = eff_width(i_cfg.bits_per_channel);
    assign chunks     = chunk_count(k);
    assign mask       = low_mask(k);
    assign sh         = 5'({2'b00, i_cur.chunk_index} * {2'b00, k});
    assign first      = (i_cur.chunk_index == 3'd0);
    assign last_chunk = (({1'b0, i_cur.chunk_index} + 4'd1) >= chunks);
    assign active     = (i_cur.phase == PH_HEADER) || (i_cur.phase == PH_PAYLOAD);
    assign len_src    = (i_cur.byte_count == 32'd0) ? i_cfg.payload_length
                                                    : i_cur.stored_length;
    assign hdr_byte   = (i_cur.byte_count < 32'(LEN_BYTES))
                        ? 8'(len_src >> {i_cur.byte_count[1:0], 3'b000}) : 8'h00;
    assign chunk_val  = 8'((i_item.carrier_byte & mask) << sh);
    assign bc_inc     = i_cur.byte_count + 32'd1;
    assign hdr_slot   = 2'(bc_inc - 32'd1);

    always_comb begin
        s = i_cur;
        r.carrier_out     = i_item.carrier_byte;
        r.payload_taken   = 1'b0;
        r.extracted_byte  = 8'h00;
        r.extracted_valid = 1'b0;
        r.extracted_last  = 1'b0;
        r.status          = ST_BUSY;

        if (active) begin
            if (i_cfg.mode == MODE_EMBED) begin
                if (first) begin
                    if (i_cur.phase == PH_HEADER) begin
                        s.stored_length = len_src;
                        s.byte_latch    = hdr_byte;
                    end else begin
                        s.byte_latch    = i_item.payload_byte;
                        r.payload_taken = 1'b1;
                    end
                end
                r.carrier_out = (i_item.carrier_byte & ~mask) | ((s.byte_latch >> sh) & mask);
            end else begin
                if (first && i_cur.phase == PH_HEADER && i_cur.byte_count == 32'd0) begin
                    s.stored_length = 32'd0;
                end
                s.byte_latch = first ? chunk_val : (i_cur.byte_latch | chunk_val);
            end

            if (last_chunk) begin
                s.chunk_index = 3'd0;
                s.byte_count  = bc_inc;
                if (i_cur.phase == PH_HEADER) begin
                    if (i_cfg.mode == MODE_EXTRACT && bc_inc <= 32'(LEN_BYTES)) begin
                        s.stored_length = s.stored_length
                                        | (32'(s.byte_latch) << {hdr_slot, 3'b000});
                    end
                    if (bc_inc >= 32'(HEADER_BYTES)) begin
                        s.byte_count = 32'd0;
                        if (i_cfg.mode == MODE_EMBED) begin
                            s.phase = (s.stored_length == 32'd0) ? PH_DONE : PH_PAYLOAD;
                        end else if (s.stored_length == 32'd0) begin
                            s.phase      = PH_ERROR;
                            s.error_code = ST_ZERO_LEN;
                        end else if (s.stored_length > i_cfg.carrier_bytes) begin
                            s.phase      = PH_ERROR;
                            s.error_code = ST_TOO_LARGE;
                        end else if (s.stored_length <= 32'(MIN_PAYLOAD)) begin
                            s.phase      = PH_ERROR;
                            s.error_code = ST_TOO_SHORT;
                        end else begin
                            s.phase = PH_PAYLOAD;
                        end
                    end
                end else begin
                    if (i_cfg.mode == MODE_EXTRACT) begin
                        r.extracted_valid = 1'b1;
                        r.extracted_byte  = s.byte_latch;
                    end
                    if (bc_inc >= s.stored_length) begin
                        s.phase = PH_DONE;
                        r.extracted_last = (i_cfg.mode == MODE_EXTRACT);
                    end
                end
            end else begin
                s.chunk_index = i_cur.chunk_index + 3'd1;
            end
        end

        case (s.phase)
            PH_DONE:  r.status = ST_DONE;
            PH_ERROR: r.status = s.error_code;
            default:  r.status = ST_BUSY;
        endcase

        if (i_item.final_carrier) begin
            if (s.phase == PH_HEADER || s.phase == PH_PAYLOAD) begin
                if (i_cfg.mode == MODE_EMBED) begin
                    r.status = ST_OVERFLOW;
                end else if (s.phase == PH_HEADER) begin
                    r.status = ST_TRUNCATED;
                end else begin
                    r.status = (s.byte_count <= 32'(MIN_PAYLOAD)) ? ST_TOO_SHORT
                                                                 : ST_TRUNCATED;
                end
            end
            s.chunk_index   = 3'd0;
            s.byte_latch    = 8'h00;
            s.byte_count    = 32'd0;
            s.stored_length = 32'd0;
            s.phase         = PH_HEADER;
            s.error_code    = ST_BUSY;
        end

        o_nxt = s;
        o_res = r;
    end

endmodule

### src/lsb_stego_embed_extract.sv
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract
// LSB steganography embedder / extractor, one carrier channel byte per item.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one carrier byte,
// the current payload byte and the last-byte flag. Output channel
// (o_out_valid / i_out_stall / o_out_data) returns one result item per input
// item, in order: modified carrier byte, payload-advance flag, extracted byte
// with valid and last flags, and status.
// The result of an accepted item is loaded into the output register and can
// be taken in the following cycle. Throughput is one item per cycle unless
// the receiver stalls a full output register; the whole step is one pass of
// logic between the stream state and the output register. When the receiver
// stalls, the output register holds its item, and the input side stalls only
// while that register is full and not being drained. Synchronous reset clears
// the stream state to the header phase and loads the register defaults (embed,
// 1 bit per channel, lengths zero). The user writes configuration through the
// APB port only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract
    import lsbse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg      r_cfg;
    t_stream   r_stream;
    t_stream   n_stream;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      in_acc;
    logic      cfg_wr;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        case (paddr[3:2])
            REG_MODE:          prdata = {31'd0, r_cfg.mode};
            REG_BITS_PER_CH:   prdata = {29'd0, r_cfg.bits_per_channel};
            REG_PAYLOAD_LEN:   prdata = r_cfg.payload_length;
            REG_CARRIER_BYTES: prdata = r_cfg.carrier_bytes;
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode             <= MODE_EMBED;
            r_cfg.bits_per_channel <= 3'd1;
            r_cfg.payload_length   <= 32'd0;
            r_cfg.carrier_bytes    <= 32'd0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:          r_cfg.mode             <= pwdata[0];
                REG_BITS_PER_CH:   r_cfg.bits_per_channel <= pwdata[2:0];
                REG_PAYLOAD_LEN:   r_cfg.payload_length   <= pwdata;
                REG_CARRIER_BYTES: r_cfg.carrier_bytes    <= pwdata;
                default:           ;
            endcase
        end
    end

    lsbse_step u_step (
        .i_cfg  (r_cfg),
        .i_cur  (r_stream),
        .i_item (i_in_data),
        .o_nxt  (n_stream),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream.chunk_index   <= 3'd0;
            r_stream.byte_latch    <= 8'h00;
            r_stream.byte_count    <= 32'd0;
            r_stream.stored_length <= 32'd0;
            r_stream.phase         <= PH_HEADER;
            r_stream.error_code    <= ST_BUSY;
            r_out_valid            <= 1'b0;
        end else begin
            if (in_acc) begin
                r_stream <= n_stream;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    a_last_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.extracted_last) |-> o_out_data.extracted_valid)
        else $error("last flag without extracted byte");

    a_taken_not_extract: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.payload_taken) |-> !o_out_data.extracted_valid)
        else $error("payload taken and byte extracted together");

    a_chunk_only_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stream.chunk_index != 3'd0) |->
            (r_stream.phase == PH_HEADER || r_stream.phase == PH_PAYLOAD))
        else $error("chunk index left open outside header or payload");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.final_carrier) |=>
            (r_stream.phase == PH_HEADER && r_stream.byte_count == 32'd0
             && r_stream.chunk_index == 3'd0))
        else $error("stream state not cleared after last carrier byte");

endmodule

### tb/lsb_stego_embed_extract_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_stego_embed_extract_tb
// Self-checking bench for the LSB embed / extract block. A queue of carrier
// items feeds a bursty driver; a monitor predicts every result item from its
// own copy of the stream state and configuration and compares it field by
// field. Directed images come first, then random phases of well-formed,
// truncated and noisy images under random register settings and output stalls.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract_tb;
    import lsbse_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1150;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 300;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    t_in_item    carrier_q[$];
    t_in_item    image_q[$];
    t_out_item   predicted_out_q[$];
    t_cfg        cfg_sh;
    t_stream     strm;

    logic        in_acc = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_started = 1'b0;
    int unsigned hold_left = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_span = 0;
    int unsigned stall_style = 0;
    int unsigned idle_cycles = 0;
    int unsigned random_items = 0;
    int unsigned n_errors = 0;
    int unsigned n_checked = 0;
    int unsigned n_writes = 0;
    int unsigned n_taken = 0;
    int unsigned n_extracted = 0;
    int unsigned n_last = 0;
    int unsigned outcome_cnt[0:7];

    lsb_stego_embed_extract u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic void clear_stream_state();
        strm = '0;
        strm.phase = PH_HEADER;
    endfunction

    // one carrier item through the embedder / extractor
    function automatic t_out_item embed_extract_step(input t_in_item it);
        t_out_item   r;
        int unsigned kw;
        int unsigned nch;
        int unsigned sh;
        logic [7:0]  msk;
        logic [31:0] wide;
        logic [63:0] hdr_word;
        logic        first;
        logic        last_chunk;
        kw  = (cfg_sh.bits_per_channel == 3'd0) ? 1 :
              (cfg_sh.bits_per_channel > 3'd4) ? 4 : cfg_sh.bits_per_channel;
        nch = (8 + kw - 1) / kw;
        msk = 8'((1 << kw) - 1);
        r = '0;
        r.carrier_out = it.carrier_byte;
        if (strm.phase == PH_HEADER || strm.phase == PH_PAYLOAD) begin
            first      = (strm.chunk_index == 3'd0);
            last_chunk = (strm.chunk_index + 1 >= nch);
            sh         = strm.chunk_index * kw;
            if (cfg_sh.mode == MODE_EMBED) begin
                if (first) begin
                    if (strm.phase == PH_HEADER) begin
                        if (strm.byte_count == 0) strm.stored_length = cfg_sh.payload_length;
                        hdr_word = {32'd0, strm.stored_length}
                                   >> ((32'd8 * strm.byte_count) & 32'd63);
                        strm.byte_latch = hdr_word[7:0];
                    end else begin
                        strm.byte_latch = it.payload_byte;
                        r.payload_taken = 1'b1;
                    end
                end
                wide = {24'd0, strm.byte_latch} >> sh;
                r.carrier_out = (it.carrier_byte & ~msk) | (wide[7:0] & msk);
            end else begin
                wide = ({24'd0, it.carrier_byte} & {24'd0, msk}) << sh;
                if (first && strm.phase == PH_HEADER && strm.byte_count == 0) begin
                    strm.stored_length = '0;
                end
                strm.byte_latch = first ? wide[7:0] : (strm.byte_latch | wide[7:0]);
            end
            if (last_chunk) begin
                strm.chunk_index = '0;
                strm.byte_count  = strm.byte_count + 1;
                if (strm.phase == PH_HEADER) begin
                    if (cfg_sh.mode == MODE_EXTRACT && strm.byte_count <= LEN_BYTES) begin
                        strm.stored_length = strm.stored_length
                            | ({24'd0, strm.byte_latch} << (8 * (strm.byte_count - 1)));
                    end
                    if (strm.byte_count >= HEADER_BYTES) begin
                        strm.byte_count = '0;
                        if (cfg_sh.mode == MODE_EMBED) begin
                            strm.phase = (strm.stored_length == 0) ? PH_DONE : PH_PAYLOAD;
                        end else if (strm.stored_length == 0) begin
                            strm.phase = PH_ERROR;
                            strm.error_code = ST_ZERO_LEN;
                        end else if (strm.stored_length > cfg_sh.carrier_bytes) begin
                            strm.phase = PH_ERROR;
                            strm.error_code = ST_TOO_LARGE;
                        end else if (strm.stored_length <= MIN_PAYLOAD) begin
                            strm.phase = PH_ERROR;
                            strm.error_code = ST_TOO_SHORT;
                        end else begin
                            strm.phase = PH_PAYLOAD;
                        end
                    end
                end else begin
                    if (cfg_sh.mode == MODE_EXTRACT) begin
                        r.extracted_valid = 1'b1;
                        r.extracted_byte  = strm.byte_latch;
                    end
                    if (strm.byte_count >= strm.stored_length) begin
                        strm.phase = PH_DONE;
                        if (cfg_sh.mode == MODE_EXTRACT) r.extracted_last = 1'b1;
                    end
                end
            end else begin
                strm.chunk_index = strm.chunk_index + 3'd1;
            end
        end
        case (strm.phase)
            PH_DONE:  r.status = ST_DONE;
            PH_ERROR: r.status = strm.error_code;
            default:  r.status = ST_BUSY;
        endcase
        if (it.final_carrier) begin
            if (strm.phase == PH_HEADER || strm.phase == PH_PAYLOAD) begin
                if (cfg_sh.mode == MODE_EMBED) r.status = ST_OVERFLOW;
                else if (strm.phase == PH_HEADER) r.status = ST_TRUNCATED;
                else r.status = (strm.byte_count <= MIN_PAYLOAD) ? ST_TOO_SHORT : ST_TRUNCATED;
            end
            outcome_cnt[r.status]++;
            clear_stream_state();
        end
        return r;
    endfunction

    task automatic check_field(input string nm, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, nm, want_v, got_v);
            n_errors++;
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_MODE:          cfg_sh.mode = value[0];
            REG_BITS_PER_CH:   cfg_sh.bits_per_channel = value[2:0];
            REG_PAYLOAD_LEN:   cfg_sh.payload_length = value;
            REG_CARRIER_BYTES: cfg_sh.carrier_bytes = value;
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (carrier_q.size() != 0 || i_in_valid || predicted_out_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    task automatic queue_item(input logic [7:0] c, input logic [7:0] p, input logic f);
        t_in_item it;
        it.carrier_byte  = c;
        it.payload_byte  = p;
        it.final_carrier = f;
        carrier_q = {carrier_q, it};
    endtask

    task automatic add_noise(input int unsigned n);
        t_in_item    it;
        int unsigned i;
        for (i = 0; i < n; i++) begin
            it.carrier_byte  = 8'($urandom);
            it.payload_byte  = 8'($urandom);
            it.final_carrier = 1'b0;
            image_q = {image_q, it};
        end
    endtask

    // low chunk first into the low kw bits of random carrier bytes
    task automatic add_coded(input logic [7:0] b, input int unsigned kw);
        t_in_item    it;
        int unsigned i;
        int unsigned nch;
        logic [7:0]  msk;
        nch = (8 + kw - 1) / kw;
        msk = 8'((1 << kw) - 1);
        for (i = 0; i < nch; i++) begin
            it.carrier_byte  = (8'($urandom) & ~msk) | (8'(b >> (i * kw)) & msk);
            it.payload_byte  = 8'($urandom);
            it.final_carrier = 1'b0;
            image_q = {image_q, it};
        end
    endtask

    task automatic flush_image(input int unsigned cnt, input logic with_final);
        t_in_item    it;
        int unsigned i;
        for (i = 0; i < cnt; i++) begin
            it = image_q[i];
            if (with_final && i == cnt - 1) it.final_carrier = 1'b1;
            carrier_q = {carrier_q, it};
        end
        image_q.delete();
    endtask

    task automatic queue_image(input logic is_extract, input int unsigned kw,
                               input logic [31:0] pl, input logic [31:0] cb,
                               output int unsigned n);
        int unsigned nch;
        int unsigned kind;
        int unsigned cut;
        int unsigned i;
        logic [31:0] len;
        nch  = (8 + kw - 1) / kw;
        kind = $urandom_range(0, 9);
        image_q.delete();
        if (!is_extract) begin
            len = (pl > 40) ? 32'd40 : pl;
            add_noise((4 + len) * nch);
            if (kind < 6) begin
                add_noise($urandom_range(0, 6));
                cut = image_q.size();
            end else if (kind < 9) begin
                cut = $urandom_range(1, image_q.size() - 1);
            end else begin
                image_q.delete();
                add_noise($urandom_range(1, 12));
                cut = image_q.size();
            end
        end else begin
            case (kind)
                0, 1, 2, 3, 4: len = $urandom_range(33, 48);
                5:             len = '0;
                6:             len = ($urandom_range(0, 2) == 0) ? 32 : $urandom_range(1, 32);
                7:             len = (cb == 32'hFFFF_FFFF) ? $urandom_range(33, 48) : cb + 1;
                8:             len = $urandom;
                default:       len = '0;
            endcase
            if (kind == 9) begin
                add_noise($urandom_range(1, 15));
                cut = image_q.size();
            end else begin
                for (i = 0; i < LEN_BYTES; i++) add_coded(len[8*i +: 8], kw);
                if (len >= 33 && len <= 48) begin
                    for (i = 0; i < len; i++) add_coded(8'($urandom), kw);
                end
                if (kind <= 4 && $urandom_range(0, 3) == 0) begin
                    cut = $urandom_range(4 * nch + 1, image_q.size() - 1);
                end else begin
                    add_noise((kind == 8) ? $urandom_range(0, 20) : $urandom_range(0, 5));
                    cut = image_q.size();
                end
            end
        end
        flush_image(cut, 1'b1);
        n = cut;
    endtask

    task automatic random_phase(input logic with_hold);
        logic        m;
        logic [2:0]  bpc;
        logic [31:0] pl;
        logic [31:0] cb;
        int unsigned pick;
        int unsigned kw;
        int unsigned phase_items;
        int unsigned n;
        m    = $urandom_range(0, 1);
        pick = $urandom_range(0, 19);
        if (pick == 0) bpc = 3'd0;
        else if (pick == 1) bpc = 3'd1;
        else if (pick <= 6) bpc = 3'd2;
        else if (pick <= 11) bpc = 3'd3;
        else if (pick <= 15) bpc = 3'd4;
        else bpc = $urandom_range(5, 7);
        pick = $urandom_range(0, 9);
        if (pick == 0) pl = '0;
        else if (pick == 1) pl = 32'hFFFF_FFFF;
        else if (pick == 2) pl = $urandom;
        else pl = $urandom_range(1, 40);
        pick = $urandom_range(0, 9);
        if (pick == 0) cb = '0;
        else if (pick == 1) cb = 32'hFFFF_FFFF;
        else if (pick == 2) cb = $urandom_range(0, 40);
        else cb = $urandom_range(40, 200);
        apb_write(REG_MODE, {31'd0, m});
        apb_write(REG_BITS_PER_CH, {29'd0, bpc});
        apb_write(REG_PAYLOAD_LEN, pl);
        apb_write(REG_CARRIER_BYTES, cb);
        kw = (bpc == 3'd0) ? 1 : (bpc > 3'd4) ? 4 : bpc;
        phase_items = 0;
        while (phase_items < 120) begin
            queue_image(m, kw, pl, cb, n);
            phase_items += n;
        end
        // sometimes leave a partial image so the next settings start mid-stream
        if ($urandom_range(0, 6) == 0) begin
            add_noise($urandom_range(1, 6));
            n = image_q.size();
            flush_image(n, 1'b0);
            phase_items += n;
        end
        random_items += phase_items;
        if (with_hold) hold_req = 1'b1;
    endtask

    // sender: bursts and gaps, payload held while stalled
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_acc)) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (carrier_q.size() != 0) begin
                i_in_data  <= carrier_q.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 15)
                                                          : $urandom_range(0, 2);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    always @(negedge i_clk) begin : stall_gen
        logic nxt;
        if (stall_span == 0) begin
            stall_span  = $urandom_range(20, 80);
            stall_style = $urandom_range(0, 3);
        end else begin
            stall_span--;
        end
        if (hold_left != 0) begin
            hold_left--;
            nxt = 1'b1;
        end else if (hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES - 1;
            nxt          = 1'b1;
        end else begin
            case (stall_style)
                0:       nxt = 1'b0;
                1:       nxt = ($urandom_range(0, 3) == 0);
                2:       nxt = ($urandom_range(0, 3) != 0);
                default: nxt = ~i_out_stall;
            endcase
        end
        i_out_stall <= nxt;
    end

    always @(posedge i_clk) begin : mon
        t_out_item want;
        logic      out_acc;
        in_acc  = i_rst_n && i_in_valid && !o_in_stall;
        out_acc = i_rst_n && o_out_valid && !i_out_stall;
        if (in_acc) predicted_out_q = {predicted_out_q, embed_extract_step(i_in_data)};
        if (out_acc) begin
            if (predicted_out_q.size() == 0) begin
                $display("%0t: unexpected result item, expected none, got 0x%0h",
                         $time, o_out_data);
                n_errors++;
            end else begin
                want = predicted_out_q.pop_front();
                n_checked++;
                n_taken     += want.payload_taken;
                n_extracted += want.extracted_valid;
                n_last      += want.extracted_last;
                check_field("carrier_out", want.carrier_out, o_out_data.carrier_out);
                check_field("payload_taken", want.payload_taken, o_out_data.payload_taken);
                check_field("extracted_byte", want.extracted_byte, o_out_data.extracted_byte);
                check_field("extracted_valid", want.extracted_valid,
                            o_out_data.extracted_valid);
                check_field("extracted_last", want.extracted_last, o_out_data.extracted_last);
                check_field("status", want.status, o_out_data.status);
            end
        end
        if (in_acc || out_acc) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : main
        int unsigned i;
        int unsigned phase_no;
        for (i = 0; i < 8; i++) outcome_cnt[i] = 0;
        cfg_sh.mode             = MODE_EMBED;
        cfg_sh.bits_per_channel = 3'd1;
        cfg_sh.payload_length   = '0;
        cfg_sh.carrier_bytes    = '0;
        clear_stream_state();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero-length embed, width code above range
        apb_write(REG_MODE, {31'd0, MODE_EMBED});
        apb_write(REG_BITS_PER_CH, 32'd7);
        apb_write(REG_PAYLOAD_LEN, 32'd0);
        apb_write(REG_CARRIER_BYTES, 32'hFFFF_FFFF);
        for (i = 0; i < 9; i++) queue_item(i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF, i == 8);
        wait_idle();

        // all-ones length never completes: overflow at image end
        apb_write(REG_PAYLOAD_LEN, 32'hFFFF_FFFF);
        apb_write(REG_BITS_PER_CH, 32'd4);
        for (i = 0; i < 4; i++) queue_item(8'hA5, 8'h5A, i == 3);
        wait_idle();

        // extract: image ends on its first item, then a zero length word
        apb_write(REG_MODE, {31'd0, MODE_EXTRACT});
        apb_write(REG_BITS_PER_CH, 32'd5);
        apb_write(REG_CARRIER_BYTES, 32'd0);
        queue_item(8'h3C, 8'h00, 1'b1);
        for (i = 0; i < 9; i++) queue_item(i[0] ? 8'hF0 : 8'h00, 8'hFF, i == 8);
        wait_idle();

        phase_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            random_phase(phase_no == 2);
            wait_idle();
            phase_no++;
        end
        repeat (4) @(posedge i_clk);
        if (predicted_out_q.size() != 0) begin
            $display("%0t: %0d result items never arrived", $time, predicted_out_q.size());
            n_errors += predicted_out_q.size();
        end
        $display("Run covered %0d carrier items over %0d register writes: %0d payload bytes",
                 n_checked, n_writes, n_taken);
        $display("taken, %0d bytes extracted, %0d last marks; image ends %s%0d/%0d/%0d/%0d/%0d/%0d",
                 n_extracted, n_last, "done/zero/large/short/trunc/overflow ",
                 outcome_cnt[ST_DONE], outcome_cnt[ST_ZERO_LEN], outcome_cnt[ST_TOO_LARGE],
                 outcome_cnt[ST_TOO_SHORT], outcome_cnt[ST_TRUNCATED], outcome_cnt[ST_OVERFLOW]);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
